>>> rtl/srr_pkg.sv
// Package for the selective-repeat receiver: codes, field widths and the controller state type.
package srr_pkg;

	// Port field widths
	localparam int SEQ_FIELD_W  = 4;
	localparam int WORD_FIELD_W = 32;
	localparam int OKIND_W      = 2;

	// Input packet kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	// Result kinds
	localparam logic [OKIND_W-1:0] OUT_ACK     = 2'd0;
	localparam logic [OKIND_W-1:0] OUT_DATA    = 2'd1;
	localparam logic [OKIND_W-1:0] OUT_FIN_ACK = 2'd2;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PROC = 4'b0010,
		ST_RD   = 4'b0100,
		ST_DLV  = 4'b1000
	} state_t;

endpackage

>>> rtl/srr_slot_ram.sv
// Payload slot memory: one write port, one read port with registered read data.
module srr_slot_ram #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [$clog2(DEPTH)-1:0]      wr_addr,
	input  logic [DATA_WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0]      rd_addr,
	output logic [DATA_WIDTH-1:0]         rd_data
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> rtl/selective_repeat_receiver.sv
// Selective-repeat ARQ receiver top level: window control, received marks and output register.
// Each input item is one packet: a data packet (sequence number and payload word) or a finish
// notice. A data packet always yields an ack of its sequence number first; if it falls inside
// the receive window its payload is buffered in the slot memory and every payload that is then
// in order from the window start is delivered, one result item each, the final result of a
// packet carrying tlast. A finish notice yields a single finish ack. A packet is accepted and
// then acked; each delivered payload is read from the slot memory (registered read data) and
// then output, with at most WINDOW payloads per packet. A new packet is accepted as soon as
// the previous one has issued its last result into the output register. Received marks live
// in flip-flops set on reset, so there is no clearing pass.
module selective_repeat_receiver #(
	parameter int SEQ_COUNT  = 16,
	parameter int WINDOW     = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [3:0] seq_num, [35:4] payload, [39:36] zero
	input  logic [0:0]  s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [3:0] ack_seq, [35:4] data_out, [39:36] zero
	output logic [1:0]  m_tuser,   // [1:0] out_kind
	output logic        m_tlast
);

	localparam int IW  = $clog2(SEQ_COUNT);
	localparam int AW  = IW + 1;
	localparam int OW  = $clog2(WINDOW + 1);
	localparam int CW  = (AW > OW) ? AW : OW;
	localparam int SW  = ((IW > srr_pkg::SEQ_FIELD_W) ? IW : srr_pkg::SEQ_FIELD_W) + 1;
	localparam int DW2 = (DATA_WIDTH > srr_pkg::WORD_FIELD_W) ? DATA_WIDTH
		: srr_pkg::WORD_FIELD_W;

	srr_pkg::state_t state_q;

	// latched packet
	logic                              kind_q;
	logic [srr_pkg::SEQ_FIELD_W-1:0]   seq_q;
	logic [srr_pkg::WORD_FIELD_W-1:0]  payload_q;

	// window state
	logic [IW-1:0]        ws_q;
	logic [OW-1:0]        open_q;
	logic [SEQ_COUNT-1:0] mark_q;
	logic [SEQ_COUNT-1:0] mark_nx;

	// output register
	logic                              out_valid_q;
	logic [srr_pkg::OKIND_W-1:0]       out_kind_q;
	logic [srr_pkg::SEQ_FIELD_W-1:0]   out_seq_q;
	logic [srr_pkg::WORD_FIELD_W-1:0]  out_data_q;
	logic                              out_last_q;

	logic                              out_free;
	logic                              emit;
	logic [srr_pkg::OKIND_W-1:0]       emit_kind;
	logic [srr_pkg::SEQ_FIELD_W-1:0]   emit_seq;
	logic [srr_pkg::WORD_FIELD_W-1:0]  emit_data;
	logic                              emit_last;

	// offset arithmetic
	logic [SW-1:0] seq_w;
	logic          seq_ok;
	logic [IW-1:0] seq_idx;
	logic [AW-1:0] d_sum;
	logic [AW-1:0] d_w;
	logic [CW-1:0] d_c;
	logic          in_win;
	logic          accept;
	logic          extend;
	logic [AW-1:0] off_sum;
	logic [AW-1:0] off_c;
	logic          clr;

	logic [IW-1:0] ws_inc;
	logic          more;
	logic [SW-1:0] ws_w;

	// slot memory
	logic                  ram_we;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic [DATA_WIDTH-1:0] ram_rdata;
	logic [DW2-1:0]        pay_ext;
	logic [DW2-1:0]        rd_ext;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == srr_pkg::ST_IDLE);

	// offset of the packet from the window start
	always_comb begin
		seq_w   = SW'(seq_q);
		seq_ok  = seq_w < SW'(SEQ_COUNT);
		seq_idx = seq_w[IW-1:0];
		d_sum   = {1'b0, seq_idx} + AW'(SEQ_COUNT) - {1'b0, ws_q};
		d_w     = (d_sum >= AW'(SEQ_COUNT)) ? d_sum - AW'(SEQ_COUNT) : d_sum;
		d_c     = CW'(d_w);
		in_win  = d_c < CW'(WINDOW);
		accept  = seq_ok && in_win;
		extend  = d_c >= CW'(open_q);
	end

	// received marks after this packet: skipped slots cleared, own slot set
	always_comb begin
		off_sum = '0;
		off_c   = '0;
		clr     = 1'b0;
		for (int i = 0; i < SEQ_COUNT; i++) begin
			off_sum = AW'(i) + AW'(SEQ_COUNT) - {1'b0, ws_q};
			off_c   = (off_sum >= AW'(SEQ_COUNT)) ? off_sum - AW'(SEQ_COUNT) : off_sum;
			clr     = extend && (CW'(off_c) >= CW'(open_q)) && (CW'(off_c) < d_c);
			if (seq_idx == IW'(i)) begin
				mark_nx[i] = 1'b1;
			end else if (clr) begin
				mark_nx[i] = 1'b0;
			end else begin
				mark_nx[i] = mark_q[i];
			end
		end
	end

	// next slot and whether delivery continues
	always_comb begin
		ws_inc = (ws_q == IW'(SEQ_COUNT - 1)) ? '0 : ws_q + IW'(1);
		more   = (open_q != OW'(1)) && mark_q[ws_inc];
		ws_w   = SW'(ws_q);
		rd_ext = DW2'(ram_rdata);
	end

	// result selection
	always_comb begin
		emit      = 1'b0;
		emit_kind = srr_pkg::OUT_ACK;
		emit_seq  = seq_q;
		emit_data = '0;
		emit_last = 1'b1;
		unique case (state_q)
			srr_pkg::ST_PROC: begin
				emit = out_free;
				if (kind_q == srr_pkg::KIND_FINISH) begin
					emit_kind = srr_pkg::OUT_FIN_ACK;
					emit_seq  = '0;
				end else begin
					emit_last = !(accept && mark_nx[ws_q]);
				end
			end
			srr_pkg::ST_DLV: begin
				emit      = out_free;
				emit_kind = srr_pkg::OUT_DATA;
				emit_seq  = ws_w[srr_pkg::SEQ_FIELD_W-1:0];
				emit_data = rd_ext[srr_pkg::WORD_FIELD_W-1:0];
				emit_last = !more;
			end
			srr_pkg::ST_IDLE, srr_pkg::ST_RD: begin
				emit = 1'b0;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// slot write on an accepted data packet
	always_comb begin
		pay_ext   = DW2'(payload_q);
		ram_wdata = pay_ext[DATA_WIDTH-1:0];
		ram_we    = (state_q == srr_pkg::ST_PROC) && out_free
			&& (kind_q == srr_pkg::KIND_DATA) && accept;
	end

	srr_slot_ram #(
		.DEPTH      (SEQ_COUNT),
		.DATA_WIDTH (DATA_WIDTH)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (seq_idx),
		.wr_data (ram_wdata),
		.rd_addr (ws_q),
		.rd_data (ram_rdata)
	);

	// controller and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srr_pkg::ST_IDLE;
			ws_q    <= '0;
			open_q  <= '0;
			mark_q  <= '1;
		end else begin
			unique case (state_q)
				srr_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= srr_pkg::ST_PROC;
					end
				end
				srr_pkg::ST_PROC: begin
					if (out_free) begin
						if (ram_we) begin
							mark_q <= mark_nx;
							if (extend) begin
								open_q <= OW'(d_c + CW'(1));
							end
						end
						state_q <= emit_last ? srr_pkg::ST_IDLE : srr_pkg::ST_RD;
					end
				end
				srr_pkg::ST_RD: begin
					state_q <= srr_pkg::ST_DLV;
				end
				srr_pkg::ST_DLV: begin
					if (out_free) begin
						ws_q    <= ws_inc;
						open_q  <= open_q - OW'(1);
						state_q <= more ? srr_pkg::ST_RD : srr_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= srr_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// packet latch
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q    <= s_tuser[0];
			seq_q     <= s_tdata[3:0];
			payload_q <= s_tdata[35:4];
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q <= emit_kind;
			out_seq_q  <= emit_seq;
			out_data_q <= emit_data;
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_data_q, out_seq_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	// the open part never exceeds the window
	a_open_le_window: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(open_q) <= CW'(WINDOW))
		else $error("open part exceeds window");

	// a delivery only happens with an open slot
	a_dlv_open: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srr_pkg::ST_DLV) |-> (open_q != '0))
		else $error("delivery with empty open part");

	// each delivery shrinks the open part by one
	a_dlv_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srr_pkg::ST_DLV && out_free) |=> (open_q == $past(open_q) - OW'(1)))
		else $error("open part did not shrink on delivery");

	// the window start stays inside the sequence space
	a_ws_range: assert property (@(posedge clk) disable iff (!arst_n)
		AW'(ws_q) < AW'(SEQ_COUNT))
		else $error("window start out of range");

endmodule
